FILE: hw/rtl/scpc_pkg.sv
// ----------------------------------------------------------------------------
// scpc_pkg
// Shared types, codes and reset values of the three-channel servo pulse
// controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpc_pkg;

  localparam int RX_DEPTH_DEF = 8;
  localparam int NUM_CH       = 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 16;
  localparam int TUSER_IN_W  = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_CMD_MIN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CMD_MAX  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CMD_STOP = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WDOG     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_VERSION  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT     = 3'd6;

  localparam logic [7:0]  RST_CMD_MIN  = 8'd110;
  localparam logic [7:0]  RST_CMD_MAX  = 8'd190;
  localparam logic [7:0]  RST_CMD_STOP = 8'd150;
  localparam logic [11:0] RST_PERIOD   = 12'd2000;
  localparam logic [3:0]  RST_WDOG     = 4'd3;
  localparam logic [7:0]  RST_VERSION  = 8'h03;
  localparam logic        RST_INIT     = 1'b1;

  localparam logic [7:0] ADDR_VERSION = 8'hC0;
  localparam logic [7:0] ADDR_INIT    = 8'hC1;

  typedef enum logic [2:0] {
    MODE_PULSE  = 3'd0,
    MODE_SECOND = 3'd1,
    MODE_START  = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_READ   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_COMMIT = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_EMIT   = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic exec;
    logic cm_read;
    logic cm_done;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic commit_ok;
    logic cm_last;
    logic sk_full;
  } dp_sts_t;

endpackage : scpc_pkg

`default_nettype wire

FILE: hw/rtl/scpc_ctrl.sv
// ----------------------------------------------------------------------------
// scpc_ctrl
// Sequencer: accepts one transaction, walks the commit of buffered bytes on
// a stop, then hands the result to the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpc_ctrl
  import scpc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  input  wire logic [TUSER_IN_W-1:0] mode_i,
  input  wire dp_sts_t               sts_i,
  output logic                       s_tready_o,
  output dp_cmd_t                    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_STOP && sts_i.commit_ok) begin
            state_d = ST_COMMIT;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_COMMIT: begin
        if (sts_i.cm_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o    = (state_q == ST_IDLE) && !sts_i.sk_full;
    cmd_o.exec    = accept;
    cmd_o.cm_read = (state_q == ST_COMMIT);
    cmd_o.cm_done = (state_q == ST_DRAIN);
    cmd_o.emit    = (state_q == ST_EMIT);
  end

endmodule : scpc_ctrl

`default_nettype wire

FILE: hw/rtl/scpc_dp.sv
// ----------------------------------------------------------------------------
// scpc_dp
// Datapath: configuration registers, period and width counters, watchdog,
// receive buffer with commit, read-back and the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpc_dp
  import scpc_pkg::*;
#(
  parameter int RxDepth = RX_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [TUSER_IN_W-1:0]  in_mode_i,
  input  wire logic [7:0]             in_data_i,
  input  wire logic                   in_first_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_sts_t                     sts_o,
  input  wire logic                   m_tready_i,
  output logic                        m_tvalid_o,
  output logic [TDATA_OUT_W-1:0]      m_tdata_o
);

  localparam int CntW = $clog2(RxDepth + 1);
  localparam int IdxW = $clog2(RxDepth);
  localparam int ResW = 12;

  logic [7:0]  min_q, max_q, stop_q, ver_q;
  logic [11:0] per_q;
  logic [3:0]  wdr_q;
  logic        init_q;

  logic [11:0]     pc_q, pc_d;
  logic [7:0]      wc_q [NUM_CH];
  logic [7:0]      wc_d [NUM_CH];
  logic [7:0]      chc_q [NUM_CH];
  logic [7:0]      chc_d [NUM_CH];
  logic [NUM_CH-1:0] lines_q, lines_d;
  logic [3:0]      wd_q, wd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      tc_q, tc_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            pend_q, pend_d;
  logic [7:0]      idx_q, idx_d;
  logic [7:0]      b0_q, b0_d;
  logic [7:0]      rd_q, rd_d;

  logic [7:0]      mem [RxDepth];
  logic [7:0]      mem_rd_q;
  logic            wr_ok;

  logic            out_v_q, out_v_d, sk_v_q, sk_v_d;
  logic [ResW-1:0] out_q, out_d, sk_q, sk_d;
  logic [ResW-1:0] res;
  logic            led;
  logic            pop;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= RST_CMD_MIN;
      max_q  <= RST_CMD_MAX;
      stop_q <= RST_CMD_STOP;
      per_q  <= RST_PERIOD;
      wdr_q  <= RST_WDOG;
      ver_q  <= RST_VERSION;
      init_q <= RST_INIT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_CMD_MIN:  min_q  <= cfg_data_i[7:0];
        CFG_CMD_MAX:  max_q  <= cfg_data_i[7:0];
        CFG_CMD_STOP: stop_q <= cfg_data_i[7:0];
        CFG_PERIOD:   per_q  <= cfg_data_i[11:0];
        CFG_WDOG:     wdr_q  <= cfg_data_i[3:0];
        CFG_VERSION:  ver_q  <= cfg_data_i[7:0];
        CFG_INIT:     init_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign wr_ok = cmd_i.exec && (in_mode_i == MODE_WRITE) && (cnt_q < CntW'(RxDepth));

  // receive buffer
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[cnt_q[IdxW-1:0]] <= in_data_i;
    end
    if (cmd_i.cm_read) begin
      mem_rd_q <= mem[k_q];
    end
  end

  always_comb begin
    logic [7:0] tc_eff;
    logic [7:0] addr;
    pc_d    = pc_q;
    wc_d    = wc_q;
    chc_d   = chc_q;
    lines_d = lines_q;
    wd_d    = wd_q;
    cnt_d   = cnt_q;
    tc_d    = tc_q;
    k_d     = k_q;
    pend_d  = 1'b0;
    idx_d   = idx_q;
    b0_d    = b0_q;
    rd_d    = rd_q;
    tc_eff  = tc_q;
    addr    = b0_q + tc_q;

    if (cmd_i.exec) begin
      rd_d = 8'd0;
      k_d  = IdxW'(1);
      case (in_mode_i)
        MODE_PULSE: begin
          if (pc_q == 12'd0) begin
            lines_d = '1;
            pc_d    = per_q;
            for (int c = 0; c < NUM_CH; c++) begin
              wc_d[c] = chc_q[c];
            end
          end else begin
            pc_d = pc_q - 12'd1;
            for (int c = 0; c < NUM_CH; c++) begin
              if (wc_q[c] == 8'd0) begin
                lines_d[c] = 1'b0;
              end else begin
                wc_d[c] = wc_q[c] - 8'd1;
              end
            end
          end
        end
        MODE_SECOND: begin
          if (wd_q != 4'd0) begin
            wd_d = wd_q - 4'd1;
          end else begin
            for (int c = 0; c < NUM_CH; c++) begin
              chc_d[c] = stop_q;
            end
            wd_d = wdr_q;
          end
        end
        MODE_START: cnt_d = '0;
        MODE_WRITE: begin
          if (wr_ok) begin
            if (cnt_q == '0) begin
              b0_d = in_data_i;
            end
            cnt_d = cnt_q + CntW'(1);
          end
        end
        MODE_READ: begin
          if (in_first_i) begin
            tc_eff = 8'd0;
          end
          addr = b0_q + tc_eff;
          priority if (addr == ADDR_VERSION) begin
            rd_d = ver_q;
          end else if (addr == ADDR_INIT) begin
            rd_d = {7'd0, init_q};
          end else begin
            rd_d = 8'd0;
          end
          tc_d = tc_eff + 8'd1;
        end
        default: ;
      endcase
    end

    if (cmd_i.cm_read) begin
      pend_d = 1'b1;
      idx_d  = b0_q + 8'(k_q) - 8'd1;
      k_d    = k_q + IdxW'(1);
    end

    if (pend_q && (idx_q < 8'(NUM_CH))) begin
      chc_d[idx_q[1:0]] = (mem_rd_q >= min_q && mem_rd_q <= max_q) ? mem_rd_q : stop_q;
    end

    if (cmd_i.cm_done) begin
      wd_d  = wdr_q;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= RST_PERIOD;
      for (int c = 0; c < NUM_CH; c++) begin
        wc_q[c]  <= 8'd0;
        chc_q[c] <= RST_CMD_STOP;
      end
      lines_q <= '0;
      wd_q    <= RST_WDOG;
      cnt_q   <= '0;
      tc_q    <= 8'd0;
      k_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      wc_q    <= wc_d;
      chc_q   <= chc_d;
      lines_q <= lines_d;
      wd_q    <= wd_d;
      cnt_q   <= cnt_d;
      tc_q    <= tc_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    b0_q  <= b0_d;
    rd_q  <= rd_d;
  end

  // output buffer: result slot plus one skid entry
  always_comb begin
    led = 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      led = led | (chc_q[c] != stop_q);
    end
  end

  assign res = {rd_q, led, lines_q};
  assign pop = out_v_q && m_tready_i;

  always_comb begin
    out_v_d = out_v_q;
    out_d   = out_q;
    sk_v_d  = sk_v_q;
    sk_d    = sk_q;
    if (pop) begin
      if (sk_v_q) begin
        out_d  = sk_q;
        sk_v_d = cmd_i.emit;
        sk_d   = res;
      end else begin
        out_v_d = cmd_i.emit;
        out_d   = res;
      end
    end else if (cmd_i.emit) begin
      if (!out_v_q) begin
        out_v_d = 1'b1;
        out_d   = res;
      end else begin
        sk_v_d = 1'b1;
        sk_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sk_q  <= sk_d;
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = {(TDATA_OUT_W - ResW)'(0), out_q};

  assign sts_o.commit_ok = (cnt_q > CntW'(1));
  assign sts_o.cm_last   = ((CntW'(k_q) + CntW'(1)) == cnt_q);
  assign sts_o.sk_full   = sk_v_q;

endmodule : scpc_dp

`default_nettype wire

FILE: hw/rtl/three_channel_servo_pwm_controller.sv
// ----------------------------------------------------------------------------
// three_channel_servo_pwm_controller
// Three servo pulse outputs driven by tick, bus write/stop and read
// transactions, with min/max command check and a seconds watchdog.
// ----------------------------------------------------------------------------
// Sequence: a result passes the sequencer's EMIT state and is registered in
//   the output buffer; a stop that commits buffered bytes first walks the
//   COMMIT and DRAIN states; commit reads one byte per cycle from the
//   receive buffer port. Flow: one transaction at a time; a result may wait
//   in the output buffer while the next runs.
// Reset: rst_ni clears all control and loads the default register values.
`timescale 1ns / 1ps
`default_nettype none

module three_channel_servo_pwm_controller
  import scpc_pkg::*;
#(
  parameter int RX_DEPTH = RX_DEPTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata_i,  // data_byte[7:0], read_first[8]
  input  wire logic [TUSER_IN_W-1:0]  s_axis_tuser_i,  // mode[2:0]
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0]      m_axis_tdata_o   // pulse_lines[2:0], led_on[3],
                                                       // read_data[11:4]
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .mode_i     (s_axis_tuser_i),
    .sts_i      (sts),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  scpc_dp #(
    .RxDepth (RX_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .in_mode_i  (s_axis_tuser_i),
    .in_data_i  (s_axis_tdata_i[7:0]),
    .in_first_i (s_axis_tdata_i[8]),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule : three_channel_servo_pwm_controller

`default_nettype wire

FILE: hw/rtl/scpc_chk.sv
// ----------------------------------------------------------------------------
// scpc_chk
// Port-level checks of the servo pulse controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scpc_chk
  import scpc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [TUSER_IN_W-1:0] s_axis_tuser_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [TDATA_OUT_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while one is in progress");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i != MODE_STOP)
      |=> ##1 m_axis_tvalid_o)
    else $error("result missing after transaction");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:12] == 4'd0))
    else $error("padding bits set in result");

endmodule : scpc_chk

bind three_channel_servo_pwm_controller scpc_chk u_scpc_chk (.*);

`default_nettype wire
